>>> design/nuve_pkg.sv
// ---------------------------------------------------------------------------
// nuve_pkg
// Shared types, widths and constants of the unison voice expander.
// ---------------------------------------------------------------------------
package nuve_pkg;

	// voice limit
	localparam int MAX_VOICES = 16;

	// field widths
	localparam int KIND_W   = 2;
	localparam int KEY_W    = 8;
	localparam int PITCH_W  = 32;
	localparam int PHASE_W  = 32;
	localparam int VEL_W    = 16;
	localparam int ID_W     = 12;
	localparam int SPREAD_W = 13;
	localparam int VCNT_W   = 5;
	localparam int VIDX_W   = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
	localparam int CIDX_W   = 2;

	// event kinds
	localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CHANGE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STOP   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

	// register indexes
	localparam logic [CIDX_W-1:0] REG_SPREAD = 2'd0;
	localparam logic [CIDX_W-1:0] REG_VCOUNT = 2'd1;
	localparam logic [CIDX_W-1:0] REG_RPHASE = 2'd2;

	// exponent divider
	localparam int DIV_BITS   = 17;
	localparam int STEP_W     = 5;
	localparam int REM_W      = 35;
	localparam int DEN_W      = 17;
	localparam int SEMI_SCALE = 24 * 256;
	localparam int EXP_W      = 20;
	localparam int EXP_BIAS   = 8;

	// exp2 series
	localparam logic [31:0] LN2_Q32   = 32'd2977044472;
	localparam int          TERMS     = 12;
	localparam int          SUM_W     = 35;

	// phase generator
	localparam logic [31:0] LFSR_SEED = 32'hACE1ACE1;
	localparam logic [31:0] LFSR_TAPS = 32'h80200003;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_INIT,
		OP_DIV_STEP,
		OP_XMUL,
		OP_TSTART,
		OP_TMUL,
		OP_TRECIP,
		OP_TACC,
		OP_PMUL,
		OP_ROUND,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t              op;
		logic [VIDX_W-1:0]   vidx;
		logic [STEP_W-1:0]   step;
	} dp_cmd_t;

	typedef struct packed {
		logic [VCNT_W-1:0]   n_eff;
		logic                bypass;
		logic                out_free;
	} dp_sts_t;

	// floor(2^32 / n) for the series divisors
	function automatic logic [31:0] recip(input logic [3:0] n);
		logic [31:0] r;
		unique case (n)
			4'd2:    r = 32'd2147483648;
			4'd3:    r = 32'd1431655765;
			4'd4:    r = 32'd1073741824;
			4'd5:    r = 32'd858993459;
			4'd6:    r = 32'd715827882;
			4'd7:    r = 32'd613566756;
			4'd8:    r = 32'd536870912;
			4'd9:    r = 32'd477218588;
			4'd10:   r = 32'd429496729;
			4'd11:   r = 32'd390451572;
			4'd12:   r = 32'd357913941;
			default: r = 32'hFFFFFFFF;
		endcase
		return r;
	endfunction

endpackage

>>> design/nuve_ifs.sv
// ---------------------------------------------------------------------------
// nuve interfaces
// Note event input, voice event output and register write channels.
// ---------------------------------------------------------------------------
interface nuve_in_if;
	logic                           valid;
	logic                           ready;
	logic [nuve_pkg::KIND_W-1:0]    event_kind;
	logic [nuve_pkg::KEY_W-1:0]     key;
	logic [nuve_pkg::PITCH_W-1:0]   pitch;
	logic [nuve_pkg::PHASE_W-1:0]   phase;
	logic [nuve_pkg::VEL_W-1:0]     velocity;
	modport source (output valid, event_kind, key, pitch, phase, velocity, input ready);
	modport sink (input valid, event_kind, key, pitch, phase, velocity, output ready);
endinterface

interface nuve_out_if;
	logic                           valid;
	logic                           ready;
	logic [nuve_pkg::KIND_W-1:0]    out_kind;
	logic [nuve_pkg::ID_W-1:0]      voice_id;
	logic [nuve_pkg::PITCH_W-1:0]   voice_pitch;
	logic [nuve_pkg::PHASE_W-1:0]   voice_phase;
	logic [nuve_pkg::VEL_W-1:0]     voice_velocity;
	logic                           last_voice;
	modport source (output valid, out_kind, voice_id, voice_pitch, voice_phase,
		voice_velocity, last_voice, input ready);
	modport sink (input valid, out_kind, voice_id, voice_pitch, voice_phase,
		voice_velocity, last_voice, output ready);
endinterface

interface nuve_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [nuve_pkg::CIDX_W-1:0]    index;
	logic [nuve_pkg::SPREAD_W-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> design/nuve_dpath.sv
// ---------------------------------------------------------------------------
// nuve_dpath
// Registers, detune arithmetic, phase generator and output register.
// ---------------------------------------------------------------------------
module nuve_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  nuve_pkg::dp_cmd_t             cmd,
	output nuve_pkg::dp_sts_t             sts,
	input  logic [nuve_pkg::KIND_W-1:0]   event_kind,
	input  logic [nuve_pkg::KEY_W-1:0]    key,
	input  logic [nuve_pkg::PITCH_W-1:0]  pitch,
	input  logic [nuve_pkg::PHASE_W-1:0]  phase,
	input  logic [nuve_pkg::VEL_W-1:0]    velocity,
	nuve_cfg_if.sink                      cfg,
	nuve_out_if.source                    vox
);

	// configuration
	logic [nuve_pkg::SPREAD_W-1:0] spread_q;
	logic [nuve_pkg::VCNT_W-1:0]   vcnt_q;
	logic                          rphase_q;

	// captured event
	logic [nuve_pkg::KIND_W-1:0]   kind_q;
	logic [nuve_pkg::KEY_W-1:0]    key_q;
	logic [nuve_pkg::PITCH_W-1:0]  pitch_q;
	logic [nuve_pkg::PHASE_W-1:0]  phase_q;
	logic [nuve_pkg::VEL_W-1:0]    vel_q;

	// arithmetic state
	logic [nuve_pkg::REM_W-1:0]    rem_q;
	logic [nuve_pkg::DEN_W-1:0]    den_q;
	logic [nuve_pkg::DIV_BITS-1:0] qt_q;
	logic                          neg_q;
	logic [5:0]                    shift_q;
	logic [31:0]                   x_q;
	logic [31:0]                   term_q;
	logic [31:0]                   p_q;
	logic [63:0]                   pr_q;
	logic [nuve_pkg::SUM_W-1:0]    sum_q;
	logic [63:0]                   prod_q;
	logic [nuve_pkg::PITCH_W-1:0]  pres_q;
	logic [31:0]                   lfsr_q;

	// output register
	logic                          ovalid_q;
	logic [nuve_pkg::KIND_W-1:0]   okind_q;
	logic [nuve_pkg::ID_W-1:0]     oid_q;
	logic [nuve_pkg::PITCH_W-1:0]  opitch_q;
	logic [nuve_pkg::PHASE_W-1:0]  ophase_q;
	logic [nuve_pkg::VEL_W-1:0]    ovel_q;
	logic                          olast_q;

	logic [nuve_pkg::VCNT_W-1:0]   n_eff;
	logic [nuve_pkg::VCNT_W:0]     two_i1;
	logic [nuve_pkg::VCNT_W:0]     n_wide;
	logic                          neg_c;
	logic [nuve_pkg::VCNT_W:0]     dist_c;
	logic [nuve_pkg::DEN_W-1:0]    den_c;
	logic [nuve_pkg::REM_W-1:0]    mix_c;
	logic [nuve_pkg::REM_W-1:0]    trial_c;
	logic [nuve_pkg::EXP_W-1:0]    e_c;
	logic [47:0]                   xp_c;
	logic [63:0]                   tp_c;
	logic [3:0]                    tn_c;
	logic [35:0]                   back_c;
	logic [35:0]                   trem_c;
	logic [31:0]                   q0_c;
	logic [31:0]                   qn_c;
	logic [nuve_pkg::SUM_W-1:0]    mr_c;
	logic [64:0]                   rsum_c;
	logic [64:0]                   rsh_c;
	logic [31:0]                   lfsr_nx;
	logic [nuve_pkg::ID_W:0]       id_c;

	// voice count clamp
	assign n_eff = (vcnt_q > nuve_pkg::VCNT_W'(nuve_pkg::MAX_VOICES))
		? nuve_pkg::VCNT_W'(nuve_pkg::MAX_VOICES) : vcnt_q;

	assign sts.n_eff    = n_eff;
	assign sts.bypass   = (kind_q == nuve_pkg::KIND_STOP) || (n_eff < nuve_pkg::VCNT_W'(2));
	assign sts.out_free = !ovalid_q || vox.ready;

	// voice offset from the center and the divider setup
	always_comb begin
		two_i1  = {(nuve_pkg::VCNT_W)'(cmd.vidx), 1'b1};
		n_wide  = (nuve_pkg::VCNT_W + 1)'(n_eff);
		neg_c   = two_i1 < n_wide;
		dist_c  = neg_c ? (n_wide - two_i1) : (two_i1 - n_wide);
		den_c   = nuve_pkg::DEN_W'(n_eff - nuve_pkg::VCNT_W'(1))
			* nuve_pkg::DEN_W'(nuve_pkg::SEMI_SCALE);
		mix_c   = nuve_pkg::REM_W'(dist_c) * nuve_pkg::REM_W'(spread_q);
		trial_c = nuve_pkg::REM_W'(den_q) << cmd.step;
	end

	// exponent and fractional multiply
	always_comb begin
		e_c  = neg_q
			? (nuve_pkg::EXP_W'(nuve_pkg::EXP_BIAS) << 16) - nuve_pkg::EXP_W'(qt_q)
			: (nuve_pkg::EXP_W'(nuve_pkg::EXP_BIAS) << 16) + nuve_pkg::EXP_W'(qt_q);
		xp_c = 48'(e_c[15:0]) * 48'(nuve_pkg::LN2_Q32);
		tp_c = 64'(term_q) * 64'(x_q);
	end

	// series term divide by reciprocal with one correction
	always_comb begin
		tn_c   = cmd.step[3:0];
		q0_c   = pr_q[63:32];
		back_c = 36'(q0_c) * 36'(tn_c);
		trem_c = 36'(p_q) - back_c;
		qn_c   = (trem_c >= 36'(tn_c)) ? q0_c + 32'd1 : q0_c;
	end

	// mantissa, rounding and saturation
	always_comb begin
		mr_c   = (sum_q + nuve_pkg::SUM_W'(2)) >> 2;
		rsum_c = {1'b0, prod_q} + (65'd1 << (shift_q - 6'd1));
		rsh_c  = rsum_c >> shift_q;
	end

	// phase generator step and voice id
	always_comb begin
		lfsr_nx = {1'b0, lfsr_q[31:1]} ^ (lfsr_q[0] ? nuve_pkg::LFSR_TAPS : 32'd0);
		id_c    = (nuve_pkg::ID_W + 1)'(n_eff) * (nuve_pkg::ID_W + 1)'(key_q)
			+ (nuve_pkg::ID_W + 1)'(cmd.vidx);
	end

	assign cfg.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spread_q <= '0;
			vcnt_q   <= nuve_pkg::VCNT_W'(1);
			rphase_q <= 1'b1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				nuve_pkg::REG_SPREAD: spread_q <= cfg.data;
				nuve_pkg::REG_VCOUNT: vcnt_q   <= cfg.data[nuve_pkg::VCNT_W-1:0];
				nuve_pkg::REG_RPHASE: rphase_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// arithmetic registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			nuve_pkg::OP_LOAD: begin
				kind_q  <= event_kind;
				key_q   <= key;
				pitch_q <= pitch;
				phase_q <= phase;
				vel_q   <= velocity;
			end
			nuve_pkg::OP_INIT: begin
				rem_q  <= (mix_c << 16) + nuve_pkg::REM_W'(den_c >> 1);
				den_q  <= den_c;
				neg_q  <= neg_c;
				qt_q   <= '0;
				pres_q <= (kind_q == nuve_pkg::KIND_STOP) ? '0 : pitch_q;
			end
			nuve_pkg::OP_DIV_STEP: begin
				if (rem_q >= trial_c) begin
					rem_q            <= rem_q - trial_c;
					qt_q[cmd.step]   <= 1'b1;
				end
			end
			nuve_pkg::OP_XMUL: begin
				x_q     <= xp_c[47:16];
				shift_q <= 6'd38 - 6'(e_c[nuve_pkg::EXP_W-1:16]);
			end
			nuve_pkg::OP_TSTART: begin
				term_q <= x_q;
				sum_q  <= (nuve_pkg::SUM_W'(1) << 32) + nuve_pkg::SUM_W'(x_q);
			end
			nuve_pkg::OP_TMUL:   p_q  <= tp_c[63:32];
			nuve_pkg::OP_TRECIP: pr_q <= 64'(p_q) * 64'(nuve_pkg::recip(tn_c));
			nuve_pkg::OP_TACC: begin
				term_q <= qn_c;
				sum_q  <= sum_q + nuve_pkg::SUM_W'(qn_c);
			end
			nuve_pkg::OP_PMUL:   prod_q <= 64'(pitch_q) * 64'(mr_c[31:0]);
			nuve_pkg::OP_ROUND:  pres_q <= (|rsh_c[64:32]) ? '1 : rsh_c[31:0];
			default: ;
		endcase
	end

	// phase generator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= nuve_pkg::LFSR_SEED;
		end else if (cmd.op == nuve_pkg::OP_EMIT && kind_q == nuve_pkg::KIND_START
			&& rphase_q) begin
			lfsr_q <= lfsr_nx;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.op == nuve_pkg::OP_EMIT) begin
			ovalid_q <= 1'b1;
		end else if (vox.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.op == nuve_pkg::OP_EMIT) begin
			okind_q  <= kind_q;
			oid_q    <= id_c[nuve_pkg::ID_W-1:0];
			opitch_q <= pres_q;
			olast_q  <= (nuve_pkg::VCNT_W'(cmd.vidx) + nuve_pkg::VCNT_W'(1)) == n_eff;
			ovel_q   <= (kind_q == nuve_pkg::KIND_STOP) ? '0 : vel_q;
			if (kind_q == nuve_pkg::KIND_START) begin
				ophase_q <= rphase_q ? lfsr_nx : phase_q;
			end else begin
				ophase_q <= '0;
			end
		end
	end

	assign vox.valid          = ovalid_q;
	assign vox.out_kind       = okind_q;
	assign vox.voice_id       = oid_q;
	assign vox.voice_pitch    = opitch_q;
	assign vox.voice_phase    = ophase_q;
	assign vox.voice_velocity = ovel_q;
	assign vox.last_voice     = olast_q;

	// stop events carry no pitch or velocity
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && okind_q == nuve_pkg::KIND_STOP |-> opitch_q == '0 && ovel_q == '0)
		else $error("stop voice with nonzero pitch or velocity");

	// change events carry zero phase
	a_change_phase: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && okind_q == nuve_pkg::KIND_CHANGE |-> ophase_q == '0)
		else $error("change voice with nonzero phase");

	// series sum stays below 2^33
	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == nuve_pkg::OP_PMUL |-> sum_q[nuve_pkg::SUM_W-1:33] == '0)
		else $error("exp2 series sum out of range");

	// the phase generator never locks up at zero
	a_lfsr_live: assert property (@(posedge clk) disable iff (!arst_n)
		lfsr_q != '0)
		else $error("phase generator reached zero");

endmodule

>>> design/nuve_ctrl.sv
// ---------------------------------------------------------------------------
// nuve_ctrl
// Sequencer: walks the voices of one event through the detune steps.
// ---------------------------------------------------------------------------
module nuve_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [nuve_pkg::KIND_W-1:0]  in_kind,
	input  nuve_pkg::dp_sts_t            sts,
	output nuve_pkg::dp_cmd_t            cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT,
		S_DIV,
		S_XMUL,
		S_TSTART,
		S_TMUL,
		S_TRECIP,
		S_TACC,
		S_PMUL,
		S_ROUND,
		S_EMIT
	} state_t;

	state_t                        state_q;
	logic [nuve_pkg::VIDX_W-1:0]   vidx_q;
	logic [nuve_pkg::STEP_W-1:0]   step_q;
	logic                          last_c;

	assign in_ready = (state_q == S_IDLE);
	assign last_c   = (nuve_pkg::VCNT_W'(vidx_q) + nuve_pkg::VCNT_W'(1)) == sts.n_eff;

	// command decode
	always_comb begin
		cmd.vidx = vidx_q;
		cmd.step = step_q;
		unique case (state_q)
			S_IDLE:   cmd.op = in_valid ? nuve_pkg::OP_LOAD : nuve_pkg::OP_NONE;
			S_INIT:   cmd.op = nuve_pkg::OP_INIT;
			S_DIV:    cmd.op = nuve_pkg::OP_DIV_STEP;
			S_XMUL:   cmd.op = nuve_pkg::OP_XMUL;
			S_TSTART: cmd.op = nuve_pkg::OP_TSTART;
			S_TMUL:   cmd.op = nuve_pkg::OP_TMUL;
			S_TRECIP: cmd.op = nuve_pkg::OP_TRECIP;
			S_TACC:   cmd.op = nuve_pkg::OP_TACC;
			S_PMUL:   cmd.op = nuve_pkg::OP_PMUL;
			S_ROUND:  cmd.op = nuve_pkg::OP_ROUND;
			S_EMIT:   cmd.op = sts.out_free ? nuve_pkg::OP_EMIT : nuve_pkg::OP_NONE;
			default:  cmd.op = nuve_pkg::OP_NONE;
		endcase
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vidx_q  <= '0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					vidx_q <= '0;
					if (in_valid && in_kind != nuve_pkg::KIND_NONE
						&& sts.n_eff != '0) begin
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					step_q  <= nuve_pkg::STEP_W'(nuve_pkg::DIV_BITS - 1);
					state_q <= sts.bypass ? S_EMIT : S_DIV;
				end
				S_DIV: begin
					if (step_q == '0) begin
						state_q <= S_XMUL;
					end else begin
						step_q <= step_q - nuve_pkg::STEP_W'(1);
					end
				end
				S_XMUL:   state_q <= S_TSTART;
				S_TSTART: begin
					step_q  <= nuve_pkg::STEP_W'(2);
					state_q <= S_TMUL;
				end
				S_TMUL:   state_q <= S_TRECIP;
				S_TRECIP: state_q <= S_TACC;
				S_TACC: begin
					if (step_q == nuve_pkg::STEP_W'(nuve_pkg::TERMS)) begin
						state_q <= S_PMUL;
					end else begin
						step_q  <= step_q + nuve_pkg::STEP_W'(1);
						state_q <= S_TMUL;
					end
				end
				S_PMUL:   state_q <= S_ROUND;
				S_ROUND:  state_q <= S_EMIT;
				S_EMIT: begin
					if (sts.out_free) begin
						if (last_c) begin
							state_q <= S_IDLE;
						end else begin
							vidx_q  <= vidx_q + nuve_pkg::VIDX_W'(1);
							state_q <= S_INIT;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// voice index stays within the voice count in the emit state
	a_vidx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> nuve_pkg::VCNT_W'(vidx_q) < sts.n_eff)
		else $error("voice index beyond voice count");

	// series divisor stays in its table range
	a_term_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TRECIP |-> step_q >= nuve_pkg::STEP_W'(2)
			&& step_q <= nuve_pkg::STEP_W'(nuve_pkg::TERMS))
		else $error("series divisor out of range");

	// a finished voice leaves the emit state once the output register frees
	a_emit_move: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT && sts.out_free |=> state_q == S_IDLE || state_q == S_INIT)
		else $error("emit did not advance");

endmodule

>>> design/note_unison_voice_expander.sv
// ---------------------------------------------------------------------------
// note_unison_voice_expander
// Expands each note event into one detuned event per unison voice.
// ---------------------------------------------------------------------------
// Usage:
//   evt_in  : note events (start, change, stop); a transfer takes one event.
//   vox_out : one voice event per voice, voice index ascending, last_voice
//             set on the final one. Kind 3 and a voice count of 0 give none.
//   cfg     : register writes (spread, voice count, random phase enable),
//             always ready; write only while the block is idle.
// Timing:
//   evt_in.ready is high only while no event is being expanded. Each stop
//   voice, and each voice when the voice count is 1, goes from init straight
//   to emit. Each detuned voice runs the 17-step exponent divider and then
//   the 11 terms of the exp2 series, each a multiply, a reciprocal multiply
//   and an accumulate step.
// Stalls:
//   A voice event waits in the output register while vox_out.ready is low;
//   the next voice is computed meanwhile and held until the register frees.
// Reset:
//   arst_n clears the sequencer and output valid, loads the register reset
//   values and reseeds the phase generator.
// ---------------------------------------------------------------------------
module note_unison_voice_expander (
	input  logic        clk,
	input  logic        arst_n,
	nuve_in_if.sink     evt_in,
	nuve_out_if.source  vox_out,
	nuve_cfg_if.sink    cfg
);

	nuve_pkg::dp_cmd_t cmd;
	nuve_pkg::dp_sts_t sts;

	// sequencer
	nuve_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (evt_in.valid),
		.in_ready (evt_in.ready),
		.in_kind  (evt_in.event_kind),
		.sts      (sts),
		.cmd      (cmd)
	);

	// arithmetic and output register
	nuve_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.event_kind (evt_in.event_kind),
		.key        (evt_in.key),
		.pitch      (evt_in.pitch),
		.phase      (evt_in.phase),
		.velocity   (evt_in.velocity),
		.cfg        (cfg),
		.vox        (vox_out)
	);

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the unison voice expander: note events go in with
// bursty timing, voice events are taken under a changing stall pattern and
// compared field by field against a local model of detune, ids and phases.
// ---------------------------------------------------------------------------
module tb_top;

	localparam int  IDLE_LIMIT = 20000;
	localparam int  SETTLE     = 1000;

	typedef struct packed {
		logic [nuve_pkg::KIND_W-1:0]  kind;
		logic [nuve_pkg::ID_W-1:0]    id;
		logic [nuve_pkg::PITCH_W-1:0] pitch;
		logic [nuve_pkg::PHASE_W-1:0] phase;
		logic [nuve_pkg::VEL_W-1:0]   vel;
		logic                         last;
	} voice_evt_t;

	logic clk;
	logic arst_n;

	nuve_in_if  evt_if();
	nuve_out_if vox_if();
	nuve_cfg_if cfg_if();

	note_unison_voice_expander u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.evt_in (evt_if),
		.vox_out(vox_if),
		.cfg    (cfg_if)
	);

	// model state and register copies
	logic [nuve_pkg::SPREAD_W-1:0] spread_q;
	logic [nuve_pkg::VCNT_W-1:0]   vcount_q;
	logic                          rphase_q;
	logic [31:0]                   lfsr_q;

	voice_evt_t voice_q[$];
	int         errors;
	int         idle_cycles;
	int         burst_left;
	int         stall_mode;
	int         mode_cycles;

	// clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	// 2^f for a Q16 fraction, Q32 result, truncated series
	function automatic logic [63:0] frac_pow2(input logic [15:0] f16);
		logic [127:0] x;
		logic [127:0] term;
		logic [127:0] sum;
		x    = ({112'd0, f16} * nuve_pkg::LN2_Q32) >> 16;
		term = 128'd1 << 32;
		sum  = term;
		for (int n = 1; n <= 12; n++) begin
			term = ((term * x) >> 32) / n;
			sum  = sum + term;
		end
		return sum[63:0];
	endfunction

	// pitch of voice idx out of n with the current spread
	function automatic logic [31:0] voice_pitch_of(input logic [31:0] pitch,
		input int unsigned n, input int unsigned idx);
		logic [127:0] offs;
		logic [127:0] den;
		logic [127:0] q;
		logic [127:0] e;
		logic [127:0] m30;
		logic [127:0] r;
		int           k;
		int           s;
		bit           neg;
		if (n < 2)
			return pitch;
		neg  = (2 * idx + 1) < n;
		offs = neg ? n - (2 * idx + 1) : (2 * idx + 1) - n;
		den  = 24 * (n - 1) * 256;
		q    = (offs * spread_q * 65536 + den / 2) / den;
		e    = neg ? (128'(nuve_pkg::EXP_BIAS) << 16) - q
			: (128'(nuve_pkg::EXP_BIAS) << 16) + q;
		k    = int'(e >> 16) - nuve_pkg::EXP_BIAS;
		m30  = (frac_pow2(e[15:0]) + 2) >> 2;
		s    = 30 - k;
		r    = ({96'd0, pitch} * m30 + (128'd1 << (s - 1))) >> s;
		if (r > 128'hFFFFFFFF)
			return 32'hFFFFFFFF;
		return r[31:0];
	endfunction

	// queue the voice events one accepted note event causes
	task automatic expand_note(input logic [1:0] kind, input logic [7:0] key,
		input logic [31:0] pitch, input logic [31:0] phase, input logic [15:0] vel);
		int unsigned n;
		voice_evt_t  v;
		n = vcount_q;
		if (kind == nuve_pkg::KIND_NONE)
			return;
		if (n > nuve_pkg::MAX_VOICES)
			n = nuve_pkg::MAX_VOICES;
		for (int unsigned i = 0; i < n; i++) begin
			v.kind = kind;
			v.id   = nuve_pkg::ID_W'(n * key + i);
			v.last = (i + 1 == n);
			if (kind == nuve_pkg::KIND_STOP) begin
				v.pitch = '0;
				v.phase = '0;
				v.vel   = '0;
			end else begin
				v.pitch = voice_pitch_of(pitch, n, i);
				v.vel   = vel;
				v.phase = '0;
				if (kind == nuve_pkg::KIND_START) begin
					if (rphase_q) begin
						lfsr_q = lfsr_q[0] ? ((lfsr_q >> 1) ^ nuve_pkg::LFSR_TAPS)
							: (lfsr_q >> 1);
						v.phase = lfsr_q;
					end else begin
						v.phase = phase;
					end
				end
			end
			voice_q.push_back(v);
		end
	endtask

	// send one note event, bursty with random gaps
	task automatic send_note(input logic [1:0] kind, input logic [7:0] key,
		input logic [31:0] pitch, input logic [31:0] phase, input logic [15:0] vel);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 2) != 0) begin
				evt_if.valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
		burst_left--;
		evt_if.valid      <= 1'b1;
		evt_if.event_kind <= kind;
		evt_if.key        <= key;
		evt_if.pitch      <= pitch;
		evt_if.phase      <= phase;
		evt_if.velocity   <= vel;
		do
			@(posedge clk);
		while (!(evt_if.valid && evt_if.ready));
		expand_note(kind, key, pitch, phase, vel);
	endtask

	// hold off until every voice event is out, then let the block settle
	task automatic drain();
		evt_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (voice_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// register write while idle
	task automatic write_reg(input logic [nuve_pkg::CIDX_W-1:0] idx,
		input int unsigned val);
		drain();
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= nuve_pkg::SPREAD_W'(val);
		do
			@(posedge clk);
		while (!(cfg_if.valid && cfg_if.ready));
		cfg_if.valid <= 1'b0;
		case (idx)
			nuve_pkg::REG_SPREAD: spread_q = nuve_pkg::SPREAD_W'(val);
			nuve_pkg::REG_VCOUNT: vcount_q = nuve_pkg::VCNT_W'(val);
			nuve_pkg::REG_RPHASE: rphase_q = val[0];
			default: ;
		endcase
	endtask

	task automatic setup(input int unsigned spread, input int unsigned n, input bit rph);
		write_reg(nuve_pkg::REG_SPREAD, spread);
		write_reg(nuve_pkg::REG_VCOUNT, n);
		write_reg(nuve_pkg::REG_RPHASE, rph);
	endtask

	// reset values: single voice, random phase
	task automatic test_reset_defaults();
		send_note(nuve_pkg::KIND_START, 8'd0, 32'd0, 32'd0, 16'd0);
		send_note(nuve_pkg::KIND_START, 8'd255, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
		send_note(nuve_pkg::KIND_CHANGE, 8'd255, 32'h12345678, 32'hFFFFFFFF, 16'hFFFF);
		send_note(nuve_pkg::KIND_STOP, 8'd255, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
		send_note(nuve_pkg::KIND_NONE, 8'd7, 32'h1000, 32'h5, 16'h5);
	endtask

	// widest spread over the most voices, saturation at full pitch
	task automatic test_full_spread();
		setup(6144, 16, 1'b0);
		send_note(nuve_pkg::KIND_START, 8'd255, 32'hFFFFFFFF, 32'hA5A5A5A5, 16'hFFFF);
		send_note(nuve_pkg::KIND_CHANGE, 8'd3, 32'h01B80000, 32'h0, 16'h4000);
		send_note(nuve_pkg::KIND_STOP, 8'd255, 32'h0, 32'h0, 16'h0);
		send_note(nuve_pkg::KIND_NONE, 8'd255, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
	endtask

	// spread past the nominal top, two voices
	task automatic test_overrange_spread();
		setup(8191, 2, 1'b1);
		send_note(nuve_pkg::KIND_START, 8'd128, 32'hFFFFFFFF, 32'h0, 16'h8000);
		send_note(nuve_pkg::KIND_CHANGE, 8'd1, 32'h00010000, 32'h0, 16'h1);
		send_note(nuve_pkg::KIND_START, 8'd200, 32'h00000001, 32'h0, 16'h7FFF);
	endtask

	// zero voices gives nothing, too many clamps to the limit
	task automatic test_voice_limits();
		setup(0, 0, 1'b1);
		send_note(nuve_pkg::KIND_START, 8'd9, 32'h00440000, 32'h0, 16'h100);
		send_note(nuve_pkg::KIND_STOP, 8'd9, 32'h0, 32'h0, 16'h0);
		setup(3000, 31, 1'b1);
		send_note(nuve_pkg::KIND_START, 8'd255, 32'h00440000, 32'h11111111, 16'h100);
		send_note(nuve_pkg::KIND_STOP, 8'd255, 32'h0, 32'h0, 16'h0);
		setup(1, 17, 1'b0);
		send_note(nuve_pkg::KIND_START, 8'd100, 32'h80000000, 32'hFFFFFFFF, 16'hFFFF);
	endtask

	// random events under a range of settings
	task automatic test_random_events();
		int unsigned spread;
		int unsigned n;
		logic [1:0]  kind;
		logic [31:0] pitch;
		for (int p = 0; p < 10; p++) begin
			spread = (p == 0) ? 0 : (p == 1) ? 6144 : (p == 2) ? 8191 : $urandom_range(0, 8191);
			n = (p == 3) ? 16 : (p == 4) ? 1 : (p == 5) ? 0 : $urandom_range(1, 5);
			setup(spread, n, 1'($urandom_range(0, 1)));
			for (int j = 0; j < 31; j++) begin
				if (j == 15)
					drain();
				kind = ($urandom_range(0, 15) == 0) ? nuve_pkg::KIND_NONE
					: 2'($urandom_range(0, 2));
				case ($urandom_range(0, 7))
					0: pitch = 32'hFFFFFFFF;
					1: pitch = 32'd0;
					2: pitch = $urandom_range(32'h00080000, 32'h00400000);
					default: pitch = $urandom;
				endcase
				send_note(kind, 8'($urandom), pitch, $urandom, 16'($urandom));
			end
		end
	endtask

	// receiver stall pattern, mode changes now and then
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vox_if.ready <= 1'b0;
			stall_mode   <= 0;
			mode_cycles  <= 0;
		end else begin
			if (mode_cycles == 0) begin
				stall_mode  <= $urandom_range(0, 3);
				mode_cycles <= $urandom_range(50, 400);
			end else begin
				mode_cycles <= mode_cycles - 1;
			end
			case (stall_mode)
				0: vox_if.ready <= 1'b1;
				1: vox_if.ready <= $urandom_range(0, 1);
				2: vox_if.ready <= ($urandom_range(0, 7) != 0);
				default: vox_if.ready <= ($urandom_range(0, 15) == 0);
			endcase
		end
	end

	// voice event check and idle watchdog
	always @(posedge clk) begin
		voice_evt_t e;
		if (arst_n) begin
			if (vox_if.valid && vox_if.ready) begin
				if (voice_q.size() == 0) begin
					report($sformatf("unexpected voice event id %0d", vox_if.voice_id));
				end else begin
					e = voice_q.pop_front();
					if (vox_if.out_kind !== e.kind)
						report($sformatf("kind %0d want %0d", vox_if.out_kind, e.kind));
					if (vox_if.voice_id !== e.id)
						report($sformatf("id %0d want %0d", vox_if.voice_id, e.id));
					if (vox_if.voice_pitch !== e.pitch)
						report($sformatf("id %0d pitch %h want %h", e.id,
							vox_if.voice_pitch, e.pitch));
					if (vox_if.voice_phase !== e.phase)
						report($sformatf("id %0d phase %h want %h", e.id,
							vox_if.voice_phase, e.phase));
					if (vox_if.voice_velocity !== e.vel)
						report($sformatf("id %0d velocity %h want %h", e.id,
							vox_if.voice_velocity, e.vel));
					if (vox_if.last_voice !== e.last)
						report($sformatf("id %0d last %b want %b", e.id,
							vox_if.last_voice, e.last));
				end
			end
			if ((vox_if.valid && vox_if.ready) || (evt_if.valid && evt_if.ready)
				|| (cfg_if.valid && cfg_if.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		errors       = 0;
		idle_cycles  = 0;
		burst_left   = 0;
		spread_q     = '0;
		vcount_q     = nuve_pkg::VCNT_W'(1);
		rphase_q     = 1'b1;
		lfsr_q       = nuve_pkg::LFSR_SEED;
		arst_n       = 1'b0;
		evt_if.valid      <= 1'b0;
		evt_if.event_kind <= nuve_pkg::KIND_START;
		evt_if.key        <= '0;
		evt_if.pitch      <= '0;
		evt_if.phase      <= '0;
		evt_if.velocity   <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= nuve_pkg::REG_SPREAD;
		cfg_if.data  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_full_spread();
		test_overrange_spread();
		test_voice_limits();
		test_random_events();

		drain();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
